@@ sv/double_ended_queue_macros.svh @@
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
// Types and constants shared by the double-ended queue files.
package deq_pkg;

   // Defaults for the top-level parameters.
   localparam int DATA_WIDTH_DEF = 32;
   localparam int DEPTH_DEF      = 256;

   // Fixed field widths of the channel payloads.
   localparam int WORD_W = 32;
   localparam int OCC_W  = 9;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      command_type        command;
      logic [WORD_W-1:0]  data_in;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0]  popped_word;
      status_type         status;
      logic [WORD_W-1:0]  front_word;
      logic [WORD_W-1:0]  back_word;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
      logic               is_full;
   } rsp_payload_type;

endpackage

@@ sv/deq_chan_if.sv @@
// Valid/ready channel interface carrying one payload item per handshake.
interface deq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/deq_store.sv @@
// Word store of the queue: one write port and one read port with registered data.
module deq_store #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH      = deq_pkg::DEPTH_DEF,
   parameter int IDX_W      = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: control, cached end words and result register.
// Timing: a push, a refused command or a pop that empties the queue has its result
// registered in the cycle after acceptance; any other pop first reads the store in
// ST_READ. Throughput: one push per cycle while each result is taken; a pop that
// leaves words behind blocks new requests while the store read refills its end word.
// Reset: synchronous, clears indices, count and cached end words; store is not cleared.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH      = deq_pkg::DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   deq_chan_if.sink   req_chan,
   deq_chan_if.source rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 2;

   // Slot arithmetic, wrapping at the store depth.
   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   deq_pkg::state_type        state_ff, state_in;
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [IDX_W-1:0]          back_ff, back_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [DATA_WIDTH-1:0]     front_word_ff, front_word_in;
   logic [DATA_WIDTH-1:0]     back_word_ff, back_word_in;
   logic [DATA_WIDTH-1:0]     popped_ff, popped_in;
   logic                      sel_front_ff, sel_front_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      rsp_load;
   deq_pkg::status_type       status_val;
   logic [DATA_WIDTH-1:0]     word_in;
   logic                      is_full_now;
   logic                      is_empty_now;
   logic [IDX_W-1:0]          front_prev;
   logic [IDX_W-1:0]          front_next;
   logic [IDX_W-1:0]          back_prev;
   logic [IDX_W-1:0]          back_prev2;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [DATA_WIDTH-1:0]     rd_data;

   // Ring consistency check: back slot equals front slot plus count, wrapped.
   logic [SUM_W-1:0]          ring_sum;
   logic [SUM_W-1:0]          ring_wrap;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == deq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign word_in      = DATA_WIDTH'(req_chan.payload.data_in);
   assign is_full_now  = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);
   assign front_prev   = slot_prev(front_ff);
   assign front_next   = slot_next(front_ff);
   assign back_prev    = slot_prev(back_ff);
   assign back_prev2   = slot_prev(back_prev);

   deq_store #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control state and cached end words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= deq_pkg::ST_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         front_word_ff <= '0;
         back_word_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         back_ff       <= back_in;
         count_ff      <= count_in;
         front_word_ff <= front_word_in;
         back_word_ff  <= back_word_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      popped_ff    <= popped_in;
      sel_front_ff <= sel_front_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Next state, store accesses and result formation.
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      popped_in     = popped_ff;
      sel_front_in  = sel_front_ff;
      status_val    = deq_pkg::STATUS_OK;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = back_ff;
      rd_en         = 1'b0;
      rd_addr       = front_next;

      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (req_fire) begin
               popped_in = '0;
               unique case (req_chan.payload.command)
                  deq_pkg::CMD_PUSH_FRONT: begin
                     rsp_load = 1'b1;
                     if (is_full_now) begin
                        status_val = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = front_prev;
                        front_in      = front_prev;
                        count_in      = count_ff + 1'b1;
                        front_word_in = word_in;
                        if (is_empty_now) begin
                           back_word_in = word_in;
                        end
                     end
                  end
                  deq_pkg::CMD_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (is_full_now) begin
                        status_val = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = back_ff;
                        back_in      = slot_next(back_ff);
                        count_in     = count_ff + 1'b1;
                        back_word_in = word_in;
                        if (is_empty_now) begin
                           front_word_in = word_in;
                        end
                     end
                  end
                  deq_pkg::CMD_POP_FRONT: begin
                     if (is_empty_now) begin
                        rsp_load   = 1'b1;
                        status_val = deq_pkg::STATUS_EMPTY;
                     end else begin
                        popped_in = front_word_ff;
                        front_in  = front_next;
                        count_in  = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           // Last word leaves: both ends read as zero.
                           rsp_load      = 1'b1;
                           front_word_in = '0;
                           back_word_in  = '0;
                        end else begin
                           rd_en        = 1'b1;
                           rd_addr      = front_next;
                           sel_front_in = 1'b1;
                           state_in     = deq_pkg::ST_READ;
                        end
                     end
                  end
                  deq_pkg::CMD_POP_BACK: begin
                     if (is_empty_now) begin
                        rsp_load   = 1'b1;
                        status_val = deq_pkg::STATUS_EMPTY;
                     end else begin
                        popped_in = back_word_ff;
                        back_in   = back_prev;
                        count_in  = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           rsp_load      = 1'b1;
                           front_word_in = '0;
                           back_word_in  = '0;
                        end else begin
                           rd_en        = 1'b1;
                           rd_addr      = back_prev2;
                           sel_front_in = 1'b0;
                           state_in     = deq_pkg::ST_READ;
                        end
                     end
                  end
               endcase
            end
         end
         deq_pkg::ST_READ: begin
            // The new end word arrives from the store.
            rsp_load = 1'b1;
            state_in = deq_pkg::ST_IDLE;
            if (sel_front_ff) begin
               front_word_in = rd_data;
            end else begin
               back_word_in = rd_data;
            end
         end
      endcase

      rsp_data_in.popped_word = deq_pkg::WORD_W'(popped_in);
      rsp_data_in.status      = status_val;
      rsp_data_in.front_word  = deq_pkg::WORD_W'(front_word_in);
      rsp_data_in.back_word   = deq_pkg::WORD_W'(back_word_in);
      rsp_data_in.occupancy   = deq_pkg::OCC_W'(count_in);
      rsp_data_in.is_empty    = (count_in == '0);
      rsp_data_in.is_full     = (count_in == CNT_W'(DEPTH));
   end

   // Result register holds its item until the consumer takes it.
   assign rsp_valid_in     = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign ring_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign ring_wrap = (ring_sum >= SUM_W'(DEPTH)) ? ring_sum - SUM_W'(DEPTH) : ring_sum;

   `DEQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "count exceeds depth")
   `DEQ_ASSERT_ALWAYS(a_ring_consistent, clock, reset, IDX_W'(ring_wrap) == back_ff, "indices disagree with count")
   `DEQ_ASSERT_IMPLY(a_read_slot_free, clock, reset, state_ff == deq_pkg::ST_READ, !rsp_valid_ff, "result register busy during store read")
   `DEQ_ASSERT_IMPLY(a_empty_words_zero, clock, reset, count_ff == '0, front_word_ff == '0 && back_word_ff == '0, "cached words not cleared when empty")
   `DEQ_ASSERT_NEXT(a_item_progress, clock, reset, req_fire, rsp_valid_ff || state_ff == deq_pkg::ST_READ, "accepted item produced no result")

endmodule
